[src/pss_pkg.sv]
// Shared types and constants for the process slot scheduler.
// Holds the request and response word layouts, operation, status, mode and
// register codes, and the control state type. Depends on nothing.
`default_nettype none

package pss_pkg;

  // Request word: one scheduler operation.
  typedef struct packed {
    logic [2:0]  operation;
    logic [5:0]  slot;
    logic [2:0]  new_status;
    logic [3:0]  prio_request;
    logic        slice_used;
    logic [31:0] now_tick;
  } req_word_t;

  // Response word: one result per request.
  typedef struct packed {
    logic [5:0] chosen_slot;
    logic       found;
    logic [2:0] slice_length;
  } rsp_word_t;

  // Operation codes.
  localparam logic [2:0] OP_ALLOC      = 3'd0;
  localparam logic [2:0] OP_SET_STATUS = 3'd1;
  localparam logic [2:0] OP_SET_PRIO   = 3'd2;
  localparam logic [2:0] OP_YIELD      = 3'd3;
  localparam logic [2:0] OP_PICK       = 3'd4;

  // Slot status codes.
  localparam logic [2:0] STAT_UNUSED   = 3'd0;
  localparam logic [2:0] STAT_USED     = 3'd1;
  localparam logic [2:0] STAT_RUNNABLE = 3'd2;
  localparam logic [2:0] STAT_RUNNING  = 3'd3;
  localparam logic [2:0] STAT_MAX      = 3'd5;

  // Scheduling modes; the unassigned code behaves as round robin.
  localparam logic [1:0] MODE_RR   = 2'd0;
  localparam logic [1:0] MODE_PRIO = 2'd1;
  localparam logic [1:0] MODE_MLFQ = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCHED_MODE       = 2'd0;
  localparam logic [1:0] CFG_BOOST_INTERVAL   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_PRIORITY = 2'd2;

  // Configuration reset values.
  localparam logic [1:0]  RST_SCHED_MODE       = MODE_RR;
  localparam logic [15:0] RST_BOOST_INTERVAL   = 16'd100;
  localparam logic [2:0]  RST_DEFAULT_PRIORITY = 3'd4;

  // Control sequencer states.
  typedef enum logic [2:0] {
    PS_IDLE,
    PS_RMW,
    PS_SCAN,
    PS_COMMIT,
    PS_DONE
  } ps_state_t;

endpackage

`default_nettype wire

[src/process_slot_scheduler.sv]
// Process slot scheduler top level: slot table memory, scan sequencer and
// response register. Depends on pss_pkg for word layouts and codes.
//
// Usage:
//   Requests arrive as req_word_t words on req/req_valid; a word is taken at a
//   clock edge where req_valid is high and req_stall is low. Each request
//   produces exactly one rsp_word_t word on rsp/rsp_valid, taken at an edge
//   where rsp_valid is high and rsp_stall is low. Configuration registers
//   (scheduling mode, boost interval, default priority) are written through
//   cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high, and
//   writes are expected only while no request is in flight.
//   One request is processed at a time. Accepted updates do a read-modify-write
//   of one entry before the response; a rejected word goes straight to the response stage.
//   Allocate and pick sweep the table through the single read port, one entry
//   per cycle, then commit the chosen entry before the response is formed.
//   A new request is accepted as soon as the previous one has been handed to
//   the response register, even while that word is still stalled. If the
//   receiver keeps stalling, the next result waits in the sequencer and
//   req_stall stays high until the response register frees up.
//   Reset (rst, synchronous) marks every slot unused through per-entry valid
//   bits, clears the round-robin pointer and boost timestamp, and restores
//   the configuration defaults. No clearing pass is needed.
`default_nettype none

module process_slot_scheduler #(
  parameter int SLOTS      = 64,
  parameter int PRIO_COUNT = 8,
  parameter int LEVELS     = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Request channel.
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire pss_pkg::req_word_t req,
  // Response channel.
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output pss_pkg::rsp_word_t      rsp,
  // Configuration write channel.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // Slot index, scan counter, stored priority and level widths. The stored
  // priority is never narrower than the default priority register.
  localparam int IW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int PW  = ($clog2(PRIO_COUNT) > 3) ? $clog2(PRIO_COUNT) : 3;
  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef struct packed {
    logic [2:0]    status;
    logic [PW-1:0] prio;
    logic [LW-1:0] level;
  } ent_t;

  // Slice granted at a feedback level: two to the level, saturating at 7.
  function automatic logic [2:0] slice_of(input logic [LW-1:0] lv);
    logic [1:0] l2;
    logic [2:0] s;
    l2 = 2'(lv);
    case (l2)
      2'd0:    s = 3'd1;
      2'd1:    s = 3'd2;
      2'd2:    s = 3'd4;
      default: s = 3'd7;
    endcase
    return s;
  endfunction

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    return (a == IW'(SLOTS - 1)) ? '0 : a + IW'(1);
  endfunction

  // Configuration registers.
  logic [1:0]  sched_mode;
  logic [15:0] boost_interval;
  logic [2:0]  default_priority;

  // Sequencer and datapath registers.
  pss_pkg::ps_state_t  state, state_next;
  pss_pkg::req_word_t  item;
  pss_pkg::rsp_word_t  res;
  logic                boost;
  logic [IW-1:0]       rr_pointer;
  logic [31:0]         last_boost;
  logic [IW-1:0]       scan_addr;
  logic [CW-1:0]       issue_cnt;
  logic                rd_pend;
  logic [IW-1:0]       rd_idx;
  logic                have;
  logic [IW-1:0]       best_idx;
  ent_t                best_ent;

  // Slot table memory and per-entry valid bits (an invalid entry is unused).
  ent_t                mem [SLOTS];
  logic [SLOTS-1:0]    vld;
  ent_t                rd_data;
  logic                rd_vld;
  logic                mem_we;
  logic [IW-1:0]       mem_wa;
  ent_t                mem_wd;
  logic [IW-1:0]       mem_ra;

  // Combinational helpers.
  ent_t                rd_eff;
  ent_t                rmw_ent;
  ent_t                boost_ent;
  ent_t                commit_ent;
  logic                is_pick;
  logic                mode_prio;
  logic                mode_fb;
  logic                in_table;
  logic                upd_ok;
  logic                scan_op;
  logic                boost_now;
  logic                req_take;
  logic                rsp_free;
  logic [LW-1:0]       lvl_eff;
  logic [PW:0]         prio_bound;
  logic                take;
  logic                boost_wr;
  logic [PW-1:0]       alloc_prio;
  pss_pkg::rsp_word_t  fail_res;
  pss_pkg::rsp_word_t  upd_res;
  pss_pkg::rsp_word_t  commit_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode       <= pss_pkg::RST_SCHED_MODE;
      boost_interval   <= pss_pkg::RST_BOOST_INTERVAL;
      default_priority <= pss_pkg::RST_DEFAULT_PRIORITY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pss_pkg::CFG_SCHED_MODE:       sched_mode       <= cfg_data[1:0];
        pss_pkg::CFG_BOOST_INTERVAL:   boost_interval   <= cfg_data;
        pss_pkg::CFG_DEFAULT_PRIORITY: default_priority <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[mem_ra];
      if (mem_we) begin
        vld[mem_wa] <= 1'b1;
      end
    end
  end

  // Decode of the request at the input and of the request being worked on.
  always_comb begin
    req_take  = req_valid && !req_stall;
    in_table  = ({26'd0, req.slot} < 32'(SLOTS));
    scan_op   = (req.operation == pss_pkg::OP_ALLOC) || (req.operation == pss_pkg::OP_PICK);
    boost_now = (req.operation == pss_pkg::OP_PICK) && (sched_mode == pss_pkg::MODE_MLFQ) &&
                ((req.now_tick - last_boost) >= {16'd0, boost_interval});
    case (req.operation)
      pss_pkg::OP_SET_STATUS: upd_ok = in_table && (req.new_status <= pss_pkg::STAT_MAX);
      pss_pkg::OP_SET_PRIO:   upd_ok = in_table && ({1'b0, req.prio_request} < 5'(PRIO_COUNT));
      pss_pkg::OP_YIELD:      upd_ok = in_table;
      default:                upd_ok = 1'b0;
    endcase

    is_pick   = (item.operation == pss_pkg::OP_PICK);
    mode_prio = is_pick && (sched_mode == pss_pkg::MODE_PRIO);
    mode_fb   = is_pick && (sched_mode == pss_pkg::MODE_MLFQ);
    rsp_free  = !rsp_valid || !rsp_stall;
  end

  // Entry as read, with a never-written slot seen as unused.
  always_comb begin
    rd_eff = rd_data;
    if (!rd_vld) begin
      rd_eff.status = pss_pkg::STAT_UNUSED;
    end
  end

  // Read-modify-write of a single slot for the update operations.
  always_comb begin
    rmw_ent = rd_eff;
    case (item.operation)
      pss_pkg::OP_SET_STATUS: rmw_ent.status = item.new_status;
      pss_pkg::OP_SET_PRIO:   rmw_ent.prio   = PW'(item.prio_request);
      default: begin
        rmw_ent.status = pss_pkg::STAT_RUNNABLE;
        // Demotion by one feedback level when the slice was used up.
        if ((sched_mode == pss_pkg::MODE_MLFQ) && item.slice_used &&
            (({1'b0, rd_eff.level} + (LW + 1)'(1)) < (LW + 1)'(LEVELS))) begin
          rmw_ent.level = rd_eff.level + LW'(1);
        end
      end
    endcase
  end

  // Scan evaluation for the entry whose read data just arrived.
  always_comb begin
    boost_wr  = boost && (rd_eff.status != pss_pkg::STAT_UNUSED);
    lvl_eff   = boost_wr ? '0 : rd_eff.level;
    boost_ent = rd_eff;
    boost_ent.level = '0;
    prio_bound = have ? {1'b0, best_ent.prio} : (PW + 1)'(PRIO_COUNT);
    if (item.operation == pss_pkg::OP_ALLOC) begin
      take = !have && (rd_eff.status == pss_pkg::STAT_UNUSED);
    end else if (mode_prio) begin
      take = (rd_eff.status == pss_pkg::STAT_RUNNABLE) && ({1'b0, rd_eff.prio} < prio_bound);
    end else if (mode_fb) begin
      take = (rd_eff.status == pss_pkg::STAT_RUNNABLE) && (!have || (lvl_eff < best_ent.level));
    end else begin
      take = !have && (rd_eff.status == pss_pkg::STAT_RUNNABLE);
    end
  end

  // Final write and response of an allocate or pick.
  always_comb begin
    alloc_prio = ({1'b0, item.prio_request} < 5'(PRIO_COUNT)) ?
                 PW'(item.prio_request) : PW'(default_priority);
    if (item.operation == pss_pkg::OP_ALLOC) begin
      commit_ent.status = pss_pkg::STAT_USED;
      commit_ent.prio   = alloc_prio;
      commit_ent.level  = '0;
    end else begin
      commit_ent        = best_ent;
      commit_ent.status = pss_pkg::STAT_RUNNING;
    end

    commit_res.chosen_slot  = have ? 6'(best_idx) : 6'd0;
    commit_res.found        = have;
    commit_res.slice_length = (have && mode_fb) ? slice_of(best_ent.level) : 3'd1;

    upd_res.chosen_slot  = item.slot;
    upd_res.found        = 1'b1;
    upd_res.slice_length = 3'd1;

    fail_res.chosen_slot  = 6'd0;
    fail_res.found        = 1'b0;
    fail_res.slice_length = 3'd1;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pss_pkg::PS_IDLE: begin
        if (req_take) begin
          if (scan_op) begin
            state_next = pss_pkg::PS_SCAN;
          end else if (upd_ok) begin
            state_next = pss_pkg::PS_RMW;
          end else begin
            state_next = pss_pkg::PS_DONE;
          end
        end
      end
      pss_pkg::PS_RMW: state_next = pss_pkg::PS_DONE;
      pss_pkg::PS_SCAN: begin
        if ((issue_cnt == CW'(SLOTS)) && !rd_pend) begin
          state_next = pss_pkg::PS_COMMIT;
        end
      end
      pss_pkg::PS_COMMIT: state_next = pss_pkg::PS_DONE;
      pss_pkg::PS_DONE: begin
        if (rsp_free) begin
          state_next = pss_pkg::PS_IDLE;
        end
      end
      default: state_next = pss_pkg::PS_IDLE;
    endcase
  end

  // Sequencer outputs: stall and memory port control.
  always_comb begin
    req_stall = 1'b1;
    mem_we    = 1'b0;
    mem_wa    = rd_idx;
    mem_wd    = boost_ent;
    mem_ra    = scan_addr;
    unique case (state)
      pss_pkg::PS_IDLE: begin
        req_stall = 1'b0;
        mem_ra    = IW'(req.slot);
      end
      pss_pkg::PS_RMW: begin
        mem_we = 1'b1;
        mem_wa = IW'(item.slot);
        mem_wd = rmw_ent;
      end
      pss_pkg::PS_SCAN: begin
        // A boosting feedback pick clears the level of each used slot as it
        // passes; the read in flight is always a different slot.
        mem_we = rd_pend && boost_wr;
      end
      pss_pkg::PS_COMMIT: begin
        mem_we = have;
        mem_wa = best_idx;
        mem_wd = commit_ent;
      end
      pss_pkg::PS_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pss_pkg::PS_IDLE;
      rr_pointer <= '0;
      last_boost <= '0;
      rsp_valid  <= 1'b0;
      rd_pend    <= 1'b0;
      have       <= 1'b0;
      issue_cnt  <= '0;
    end else begin
      state <= state_next;

      // A new word may load in the same cycle that the old one is taken.
      if ((state == pss_pkg::PS_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        pss_pkg::PS_IDLE: begin
          if (req_take) begin
            item      <= req;
            res       <= fail_res;
            boost     <= boost_now;
            have      <= 1'b0;
            rd_pend   <= 1'b0;
            issue_cnt <= '0;
            // Round robin resumes after the last pick; everything else
            // sweeps from slot zero.
            scan_addr <= ((req.operation == pss_pkg::OP_PICK) &&
                          (sched_mode != pss_pkg::MODE_PRIO) &&
                          (sched_mode != pss_pkg::MODE_MLFQ)) ? rr_pointer : '0;
            if (boost_now) begin
              last_boost <= req.now_tick;
            end
          end
        end
        pss_pkg::PS_RMW: begin
          res <= upd_res;
        end
        pss_pkg::PS_SCAN: begin
          if (issue_cnt != CW'(SLOTS)) begin
            scan_addr <= wrap_inc(scan_addr);
            issue_cnt <= issue_cnt + CW'(1);
            rd_idx    <= scan_addr;
            rd_pend   <= 1'b1;
          end else begin
            rd_pend   <= 1'b0;
          end
          if (rd_pend && take) begin
            have     <= 1'b1;
            best_idx <= rd_idx;
            best_ent <= boost_wr ? boost_ent : rd_eff;
          end
        end
        pss_pkg::PS_COMMIT: begin
          res <= commit_res;
          if (have && is_pick && !mode_prio && !mode_fb) begin
            rr_pointer <= wrap_inc(best_idx);
          end
        end
        pss_pkg::PS_DONE: begin
          if (rsp_free) begin
            rsp <= res;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
